### rtl/upm_pkg.sv
// Shared types, constants and command/status words for the USB power meter level detector.
// No dependencies; every other file of the block imports this package.
package upm_pkg;

	localparam int AVG_LOG2_DEF = 4;
	localparam int ADC_BITS_DEF = 12;

	localparam int SCALE_W    = 24;
	localparam int SCALE_FRAC = 16;
	localparam int HOLD_W     = 8;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int MV_W       = 16;
	localparam int PWR_W      = 23;
	localparam int LEVEL_W    = 3;
	localparam int OP_W       = 2;

	// Shared multiplier: 32 x 29 bits, product registered.
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 29;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// floor(x / 1000) = (x * 274877907) >> 38 for any 32 bit x.
	localparam logic [MUL_B_W-1:0] DIV1000_MUL   = 29'd274877907;
	localparam int                 DIV1000_SHIFT = MUL_P_W - PWR_W;

	localparam logic [SCALE_W-1:0] VOLTAGE_SCALE_RST = 24'd528129;
	localparam logic [SCALE_W-1:0] CURRENT_SCALE_RST = 24'd105626;
	localparam logic [HOLD_W-1:0]  HOLDOFF_RST       = 8'd10;

	localparam logic [PWR_W-1:0] PWR_MAX = 23'd4294836;

	// Requested supply levels.
	localparam logic [LEVEL_W-1:0] LEVEL_5V  = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_9V  = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_12V = 3'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_15V = 3'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_20V = 3'd4;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_20V;

	// Whole-volt bands expressed in millivolts (low inclusive, high inclusive).
	localparam logic [MV_W-1:0] BAND_5V_LO  = 16'd4000;
	localparam logic [MV_W-1:0] BAND_5V_HI  = 16'd6999;
	localparam logic [MV_W-1:0] BAND_9V_LO  = 16'd8000;
	localparam logic [MV_W-1:0] BAND_9V_HI  = 16'd10999;
	localparam logic [MV_W-1:0] BAND_12V_LO = 16'd11000;
	localparam logic [MV_W-1:0] BAND_12V_HI = 16'd13999;
	localparam logic [MV_W-1:0] BAND_15V_LO = 16'd14000;
	localparam logic [MV_W-1:0] BAND_15V_HI = 16'd16999;
	localparam logic [MV_W-1:0] BAND_20V_LO = 16'd19000;
	localparam logic [MV_W-1:0] BAND_20V_HI = 16'd21999;

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE  = 2'd0,
		OP_UP      = 2'd1,
		OP_DOWN    = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOLTAGE_SCALE = 2'd0,
		REG_CURRENT_SCALE = 2'd1,
		REG_HOLDOFF_COUNT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MSEL_VOLT  = 2'd0,
		MSEL_CURR  = 2'd1,
		MSEL_POWER = 2'd2,
		MSEL_DIV   = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     accept;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sat_volt;
		logic     sat_curr;
		logic     power_en;
		logic     load_out;
	} upm_cmd_t;

	typedef struct packed {
		logic avg_done;
	} upm_status_t;

endpackage

### rtl/upm_if.sv
// Valid/ready channel interfaces for sample words and result words.
// Depends on upm_pkg for field widths.
interface upm_item_if import upm_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [ADC_BITS-1:0] voltage_sample;
	logic [ADC_BITS-1:0] current_sample;

	modport source (output valid, output opcode, output voltage_sample,
		output current_sample, input ready);
	modport sink (input valid, input opcode, input voltage_sample,
		input current_sample, output ready);
endinterface

interface upm_result_if import upm_pkg::*;;
	logic               valid;
	logic               ready;
	logic               average_ready;
	logic [MV_W-1:0]    voltage_mv;
	logic [MV_W-1:0]    current_ma;
	logic [PWR_W-1:0]   power_mw;
	logic [LEVEL_W-1:0] supply_level;
	logic               level_changed;

	modport source (output valid, output average_ready, output voltage_mv,
		output current_ma, output power_mw, output supply_level,
		output level_changed, input ready);
	modport sink (input valid, input average_ready, input voltage_mv,
		input current_ma, input power_mw, input supply_level,
		input level_changed, output ready);
endinterface

### rtl/upm_ctrl.sv
// Sequencing state machine: accepts words, steps the shared multiplier, loads the result.
// Depends on upm_pkg for the command and status words.
module upm_ctrl import upm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	output logic        result_valid,
	input  logic        result_ready,
	input  upm_status_t status,
	output upm_cmd_t    cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL_V = 8'b0000_0010,
		ST_MUL_I = 8'b0000_0100,
		ST_SAT_I = 8'b0000_1000,
		ST_MUL_P = 8'b0001_0000,
		ST_DIV   = 8'b0010_0000,
		ST_PWR   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign out_free     = !out_valid_q || result_ready;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = MSEL_VOLT;
		cmd.accept  = item_valid && item_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					state_d = status.avg_done ? ST_MUL_V : ST_OUT;
				end
			end
			ST_MUL_V: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_VOLT;
				state_d     = ST_MUL_I;
			end
			ST_MUL_I: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MSEL_CURR;
				cmd.sat_volt = 1'b1;
				state_d      = ST_SAT_I;
			end
			ST_SAT_I: begin
				cmd.sat_curr = 1'b1;
				state_d      = ST_MUL_P;
			end
			ST_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_POWER;
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_DIV;
				state_d     = ST_PWR;
			end
			ST_PWR: begin
				cmd.power_en = 1'b1;
				state_d      = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is empty or being drained
				cmd.load_out = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/upm_dp.sv
// Datapath: configuration registers, sample sums, shared multiplier, level logic, output register.
// Depends on upm_pkg; driven by upm_ctrl commands.
module upm_dp import upm_pkg::*; #(
	parameter int AVG_LOG2 = AVG_LOG2_DEF,
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic [OP_W-1:0]      opcode,
	input  logic [ADC_BITS-1:0]  voltage_sample,
	input  logic [ADC_BITS-1:0]  current_sample,
	input  upm_cmd_t             cmd,
	output upm_status_t          status,
	output logic                 average_ready,
	output logic [MV_W-1:0]      voltage_mv,
	output logic [MV_W-1:0]      current_ma,
	output logic [PWR_W-1:0]     power_mw,
	output logic [LEVEL_W-1:0]   supply_level,
	output logic                 level_changed
);

	localparam int SUM_W = ADC_BITS + AVG_LOG2;
	localparam int CNT_W = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << AVG_LOG2) - 1);

	logic [SCALE_W-1:0]  vscale_q, iscale_q;
	logic [HOLD_W-1:0]   holdoff_cfg_q, holdoff_q, hold_dec;
	logic [SUM_W-1:0]    vsum_q, isum_q, vsum_add, isum_add;
	logic [CNT_W-1:0]    cnt_q;
	logic [LEVEL_W-1:0]  level_q, prev_level_q;
	logic                avg_flag_q;
	logic [ADC_BITS-1:0] avg_v_q, avg_i_q;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [MUL_P_W-1:0]  mul_q;
	logic [MV_W-1:0]     sat_val, mv_q, ma_q;
	logic [PWR_W-1:0]    pwr_q;
	op_t                 op;

	logic               out_avg_q, out_chg_q;
	logic [MV_W-1:0]    out_mv_q, out_ma_q;
	logic [PWR_W-1:0]   out_pwr_q;
	logic [LEVEL_W-1:0] out_lvl_q;

	function automatic logic [LEVEL_W-1:0] band_level(input logic [MV_W-1:0] mv,
		input logic [LEVEL_W-1:0] cur);
		logic [LEVEL_W-1:0] lvl;
		lvl = cur;
		priority if (mv >= BAND_5V_LO && mv <= BAND_5V_HI) lvl = LEVEL_5V;
		else if (mv >= BAND_9V_LO && mv <= BAND_9V_HI) lvl = LEVEL_9V;
		else if (mv >= BAND_12V_LO && mv <= BAND_12V_HI) lvl = LEVEL_12V;
		else if (mv >= BAND_15V_LO && mv <= BAND_15V_HI) lvl = LEVEL_15V;
		else if (mv >= BAND_20V_LO && mv <= BAND_20V_HI) lvl = LEVEL_20V;
		else lvl = cur;
		return lvl;
	endfunction

	assign op              = op_t'(opcode);
	assign vsum_add        = vsum_q + SUM_W'(voltage_sample);
	assign isum_add        = isum_q + SUM_W'(current_sample);
	assign status.avg_done = (op == OP_SAMPLE) && (cnt_q == CNT_LAST);
	assign hold_dec        = (holdoff_q != '0) ? holdoff_q - 1'b1 : holdoff_q;

	// Drop the Q16 fraction, clamp to 16 bits.
	assign sat_val = (|mul_q[MUL_P_W-1:SCALE_FRAC+MV_W]) ? '1
		: mul_q[SCALE_FRAC+MV_W-1:SCALE_FRAC];

	always_comb begin
		unique case (cmd.mul_sel)
			MSEL_VOLT: begin
				mul_a = MUL_A_W'(avg_v_q);
				mul_b = MUL_B_W'(vscale_q);
			end
			MSEL_CURR: begin
				mul_a = MUL_A_W'(avg_i_q);
				mul_b = MUL_B_W'(iscale_q);
			end
			MSEL_POWER: begin
				mul_a = MUL_A_W'(mv_q);
				mul_b = MUL_B_W'(ma_q);
			end
			MSEL_DIV: begin
				mul_a = mul_q[MUL_A_W-1:0];
				mul_b = DIV1000_MUL;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vscale_q      <= VOLTAGE_SCALE_RST;
			iscale_q      <= CURRENT_SCALE_RST;
			holdoff_cfg_q <= HOLDOFF_RST;
			vsum_q        <= '0;
			isum_q        <= '0;
			cnt_q         <= '0;
			holdoff_q     <= '0;
			level_q       <= LEVEL_5V;
			prev_level_q  <= LEVEL_5V;
			avg_flag_q    <= 1'b0;
			mv_q          <= '0;
			ma_q          <= '0;
			pwr_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_VOLTAGE_SCALE: vscale_q <= cfg_wdata[SCALE_W-1:0];
					REG_CURRENT_SCALE: iscale_q <= cfg_wdata[SCALE_W-1:0];
					REG_HOLDOFF_COUNT: holdoff_cfg_q <= cfg_wdata[HOLD_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				prev_level_q <= level_q;
				avg_flag_q   <= status.avg_done;
				unique case (op)
					OP_SAMPLE: begin
						if (status.avg_done) begin
							vsum_q <= '0;
							isum_q <= '0;
							cnt_q  <= '0;
						end else begin
							vsum_q <= vsum_add;
							isum_q <= isum_add;
							cnt_q  <= cnt_q + 1'b1;
						end
					end
					OP_UP: begin
						if (level_q < LEVEL_MAX) level_q <= level_q + 1'b1;
					end
					OP_DOWN: begin
						if (level_q != LEVEL_5V) level_q <= level_q - 1'b1;
					end
					OP_RESTART: begin
						vsum_q    <= '0;
						isum_q    <= '0;
						cnt_q     <= '0;
						holdoff_q <= holdoff_cfg_q;
					end
					default: ;
				endcase
			end
			if (cmd.sat_volt) begin
				mv_q <= sat_val;
			end
			if (cmd.sat_curr) begin
				ma_q      <= sat_val;
				holdoff_q <= hold_dec;
				if (hold_dec == '0) level_q <= band_level(mv_q, level_q);
			end
			if (cmd.power_en) begin
				pwr_q <= mul_q[MUL_P_W-1:DIV1000_SHIFT];
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept && status.avg_done) begin
			avg_v_q <= vsum_add[SUM_W-1:AVG_LOG2];
			avg_i_q <= isum_add[SUM_W-1:AVG_LOG2];
		end
		if (cmd.mul_en) begin
			mul_q <= mul_a * mul_b;
		end
		if (cmd.load_out) begin
			out_avg_q <= avg_flag_q;
			out_mv_q  <= mv_q;
			out_ma_q  <= ma_q;
			out_pwr_q <= pwr_q;
			out_lvl_q <= level_q;
			out_chg_q <= (level_q != prev_level_q);
		end
	end

	assign average_ready = out_avg_q;
	assign voltage_mv    = out_mv_q;
	assign current_ma    = out_ma_q;
	assign power_mw      = out_pwr_q;
	assign supply_level  = out_lvl_q;
	assign level_changed = out_chg_q;

endmodule

### rtl/usb_power_meter_level_detect.sv
// Top level of the USB power meter level detector: controller, datapath and channel hookup.
// Depends on upm_pkg, upm_if.sv, upm_ctrl and upm_dp.
//
// The block takes one word at a time on the item channel: a voltage/current sample pair,
// a level up or down request, or a measurement restart, and returns exactly one result
// word for each. Sample pairs are summed; every 2**AVG_LOG2 pairs the sums are averaged
// by a shift, scaled to mV and mA with the Q16 factors in registers 0 and 1 (saturating
// at 65535), and multiplied into power in mW (the divide by 1000 is a reciprocal
// multiply). A restart clears the sums and arms a hold-off of holdoff_count averages
// (register 2); once it has run out, each average picks the supply level from the
// measured whole volts. Results not taken wait in an output register while the next
// item is already accepted. A level request, restart or sample that does not close an
// average goes from acceptance straight to the output state, which loads the result
// register and reopens the item side once the output register is free or being drained.
// A sample that closes an average first steps through volts, amps, current saturation,
// power, divide and power load, as one 32x29 multiplier is used in turn for volts, amps,
// power and the divide by 1000, each product registered before the next step.
// Configuration must be written only while idle; the block itself does not enforce this.
module usb_power_meter_level_detect import upm_pkg::*; #(
	parameter int AVG_LOG2 = AVG_LOG2_DEF,
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	upm_item_if.sink             item,
	upm_result_if.source         result
);

	upm_cmd_t    cmd;
	upm_status_t status;

	// Sequence each word: accept, multiplier steps for a sample that closes an average, then load the output register.
	upm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	// Sums, scaling, power, level selection and the result register.
	upm_dp #(
		.AVG_LOG2 (AVG_LOG2),
		.ADC_BITS (ADC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.opcode         (item.opcode),
		.voltage_sample (item.voltage_sample),
		.current_sample (item.current_sample),
		.cmd            (cmd),
		.status         (status),
		.average_ready  (result.average_ready),
		.voltage_mv     (result.voltage_mv),
		.current_ma     (result.current_ma),
		.power_mw       (result.power_mw),
		.supply_level   (result.supply_level),
		.level_changed  (result.level_changed)
	);

	// Level stays within the five supply settings.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.supply_level <= LEVEL_MAX)
		else $error("supply level out of range");

	// Power never exceeds the product of two saturated 16 bit values over 1000.
	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.power_mw <= PWR_MAX)
		else $error("power beyond maximum");

	// One word in flight: after an accept the item side closes.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("second word accepted while busy");

endmodule
